[rtl/rwl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the reader/writer lock table: request word,
// operation and status codes, holder count limits and default sizes.
// ----------------------------------------------------------------------------
package rwl_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int LOCK_ENTRIES_DEF = 16;
    localparam int HANDLE_SLOTS_DEF = 64;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Holder count: positive is readers, minus one is a single writer.
    localparam logic signed [7:0] HOLDERS_MAX   = 8'sd127;
    localparam logic signed [7:0] HOLDER_WRITER = -8'sd1;
    localparam logic signed [7:0] HOLDER_ONE    = 8'sd1;
    localparam logic signed [7:0] HOLDER_ZERO   = 8'sd0;

    // Classified request word as it travels from front to back.
    typedef struct packed {
        logic        operation;
        logic [5:0]  handle;
        logic [31:0] device;
        logic [63:0] inode;
        logic        want_write;
        logic        handle_ok;
    } rwl_req_t;

endpackage

[rtl/rwl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_front
// Accepts request words, checks the handle against the slot count and
// queues the classified words for the back end.
// ----------------------------------------------------------------------------
module rwl_front
    import rwl_pkg::*;
#(
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [5:0]  s_handle,
    input  logic [31:0] s_device,
    input  logic [63:0] s_inode,
    input  logic        s_want_write,
    output logic        q_valid,
    input  logic        q_ready,
    output rwl_req_t    q_word
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rwl_req_t       queue_mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    rwl_req_t       in_word;
    logic           push;
    logic           pop;

    // Classify the incoming word.
    always_comb begin
        in_word.operation   = s_operation;
        in_word.handle      = s_handle;
        in_word.device      = s_device;
        in_word.inode       = s_inode;
        in_word.want_write  = s_want_write;
        in_word.handle_ok   = (32'(s_handle) < 32'(HANDLE_SLOTS));
    end

    assign s_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_word  = queue_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_word;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/rwl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_back
// Executes queued requests against the lock table and handle map in a
// look-up step and an execute step, and holds the status word.
// ----------------------------------------------------------------------------
module rwl_back
    import rwl_pkg::*;
#(
    parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  rwl_req_t   q_word,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status
);

    localparam int EW  = $clog2(LOCK_ENTRIES);
    localparam int HW  = $clog2(HANDLE_SLOTS);
    localparam int HXW = (HW > 6) ? HW : 6;

    typedef enum logic [1:0] {
        BK_LOOK = 2'b01,
        BK_EXEC = 2'b10
    } bk_state_t;

    bk_state_t              state_reg;
    bk_state_t              state_next;

    // Lock table.
    logic [LOCK_ENTRIES-1:0] entry_valid_reg;
    logic [31:0]             entry_device_reg  [LOCK_ENTRIES];
    logic [63:0]             entry_inode_reg   [LOCK_ENTRIES];
    logic signed [7:0]       entry_holders_reg [LOCK_ENTRIES];

    // Handle map.
    logic [HANDLE_SLOTS-1:0] handle_valid_reg;
    logic [EW-1:0]           handle_entry_mem [HANDLE_SLOTS];

    // Look-up results.
    rwl_req_t       req_reg;
    logic           hit_reg;
    logic [EW-1:0]  hit_idx_reg;
    logic           free_reg;
    logic [EW-1:0]  free_idx_reg;
    logic           hval_reg;
    logic [EW-1:0]  hent_reg;

    logic           m_valid_reg;
    logic [1:0]     m_status_reg;

    logic           hit;
    logic [EW-1:0]  hit_idx;
    logic           free;
    logic [EW-1:0]  free_idx;
    logic [HXW-1:0] q_hext;
    logic [HW-1:0]  q_hidx;
    logic [HXW-1:0] r_hext;
    logic [HW-1:0]  r_hidx;

    logic              exec_go;
    logic [EW-1:0]     sel_idx;
    logic signed [7:0] holders_cur;
    logic signed [7:0] holders_new;
    logic [1:0]        status_new;
    logic              wr_alloc;
    logic              wr_holders;
    logic              wr_free;
    logic              wr_hmap;
    logic              clr_hmap;

    assign q_hext = HXW'(q_word.handle);
    assign q_hidx = q_hext[HW-1:0];
    assign r_hext = HXW'(req_reg.handle);
    assign r_hidx = r_hext[HW-1:0];

    // Parallel key compare; the lowest matching and the lowest free entry win.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
            if (entry_valid_reg[i]) begin
                if (entry_device_reg[i] == q_word.device &&
                    entry_inode_reg[i] == q_word.inode) begin
                    hit     = 1'b1;
                    hit_idx = EW'(i);
                end
            end else begin
                free     = 1'b1;
                free_idx = EW'(i);
            end
        end
    end

    assign q_ready = (state_reg == BK_LOOK);
    assign exec_go = (state_reg == BK_EXEC) && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOOK: begin
                if (q_valid) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (exec_go) begin
                    state_next = BK_LOOK;
                end
            end
            default: state_next = BK_LOOK;
        endcase
    end

    // Decide the outcome and the table updates of the current request.
    always_comb begin
        sel_idx     = (req_reg.operation == OP_UNLOCK) ? hent_reg : hit_idx_reg;
        holders_cur = entry_holders_reg[sel_idx];
        holders_new = holders_cur;
        status_new  = ST_DONE;
        wr_alloc    = 1'b0;
        wr_holders  = 1'b0;
        wr_free     = 1'b0;
        wr_hmap     = 1'b0;
        clr_hmap    = 1'b0;
        if (req_reg.operation == OP_LOCK) begin
            if (!req_reg.handle_ok) begin
                status_new = ST_CONFLICT;
            end else if (!hit_reg) begin
                if (!free_reg) begin
                    status_new = ST_FULL;
                end else begin
                    wr_alloc = 1'b1;
                    wr_hmap  = 1'b1;
                end
            end else if (req_reg.want_write || holders_cur < HOLDER_ZERO ||
                         holders_cur >= HOLDERS_MAX) begin
                status_new = ST_CONFLICT;
            end else begin
                holders_new = holders_cur + HOLDER_ONE;
                wr_holders  = 1'b1;
                wr_hmap     = 1'b1;
            end
        end else begin
            if (!req_reg.handle_ok || !hval_reg) begin
                status_new = ST_NOT_HELD;
            end else begin
                clr_hmap = 1'b1;
                if (32'(hent_reg) >= LOCK_ENTRIES || !entry_valid_reg[hent_reg]) begin
                    status_new = ST_NOT_HELD;
                end else begin
                    if (holders_cur < HOLDER_ZERO) begin
                        holders_new = holders_cur + HOLDER_ONE;
                    end else if (holders_cur > HOLDER_ZERO) begin
                        holders_new = holders_cur - HOLDER_ONE;
                    end
                    wr_holders = 1'b1;
                    wr_free    = (holders_new == HOLDER_ZERO);
                end
            end
        end
    end

    // Control state, valid bits and output handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= BK_LOOK;
            entry_valid_reg  <= '0;
            handle_valid_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_go) begin
                if (wr_alloc) begin
                    entry_valid_reg[free_idx_reg] <= 1'b1;
                end
                if (wr_free) begin
                    entry_valid_reg[sel_idx] <= 1'b0;
                end
                if (wr_hmap) begin
                    handle_valid_reg[r_hidx] <= 1'b1;
                end
                if (clr_hmap) begin
                    handle_valid_reg[r_hidx] <= 1'b0;
                end
            end
        end
    end

    // Look-up registers and handle map read.
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            req_reg      <= q_word;
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_reg     <= free;
            free_idx_reg <= free_idx;
            hval_reg     <= handle_valid_reg[q_hidx];
            hent_reg     <= handle_entry_mem[q_hidx];
        end
    end

    // Table payload, handle map write and status word.
    always_ff @(posedge aclk) begin
        if (exec_go) begin
            m_status_reg <= status_new;
            if (wr_alloc) begin
                entry_device_reg[free_idx_reg]  <= req_reg.device;
                entry_inode_reg[free_idx_reg]   <= req_reg.inode;
                entry_holders_reg[free_idx_reg] <= req_reg.want_write ?
                                                   HOLDER_WRITER : HOLDER_ONE;
                handle_entry_mem[r_hidx]        <= free_idx_reg;
            end
            if (wr_holders) begin
                entry_holders_reg[sel_idx] <= holders_new;
            end
            if (wr_hmap && !wr_alloc) begin
                handle_entry_mem[r_hidx] <= hit_idx_reg;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

endmodule

[rtl/reader_writer_lock_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// Table of locked objects keyed by device and inode, with reader/writer
// holder counts and a map from handle to table entry.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one request word per handshake: operation (lock or
// release), handle, device, inode and want_write. The m_ channel returns
// one status word per request, in request order.
// A request passes a two-word queue, then the back end does the parallel
// key compare and handle map read in its look-up step and registers the
// results, then does the read-modify-write of the holder count and map in
// its execute step, which waits while the status output is stalled. The
// back end takes no new request before its last one has been executed.
// Reset clears the entry valid bits and handle valid bits at once, so the
// block takes requests from the first cycle after reset.
// When the receiver stalls, the status word is held in the output register
// and the back end waits in its execute step; the queue keeps taking words
// until it holds two, then s_ready drops.
// ----------------------------------------------------------------------------
module reader_writer_lock_table
    import rwl_pkg::*;
#(
    parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [5:0]  s_handle,
    input  logic [31:0] s_device,
    input  logic [63:0] s_inode,
    input  logic        s_want_write,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status
);

    logic     q_valid;
    logic     q_ready;
    rwl_req_t q_word;

    // Front end: classify and queue.
    rwl_front #(
        .HANDLE_SLOTS (HANDLE_SLOTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_handle      (s_handle),
        .s_device      (s_device),
        .s_inode       (s_inode),
        .s_want_write  (s_want_write),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_word        (q_word)
    );

    // Back end: table look-up and update.
    rwl_back #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .HANDLE_SLOTS (HANDLE_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_word   (q_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status)
    );

endmodule
